// ----- hw/rtl/pttf_pkg.sv -----
// shared types and constants for the pid tagged tlb with fifo replacement
// no dependencies
`default_nettype none

package pttf_pkg;

    localparam int OP_W    = 3;
    localparam int PAGE_W  = 16;
    localparam int PID_W   = 8;
    localparam int FRAME_W = 12;
    localparam int SLOT_OUT_W = 4;

    localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
    localparam logic [OP_W-1:0] OP_INVAL     = 3'd2;
    localparam logic [OP_W-1:0] OP_FLUSH_PID = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH_ALL = 3'd4;

    // command held for the whole walk and broadcast to every cell
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [PAGE_W-1:0]  page;
        logic [PID_W-1:0]   pid;
        logic [FRAME_W-1:0] frame;
    } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pid_tagged_tlb_fifo.sv -----
// fully associative tlb, pid and page tagged, fifo replacement, one slot per cell.
// each item walks as a token down the cell chain and is then committed in the done state;
// a new item is taken only once the previous one has committed, but a result may wait
// in the output register while the next item is taken.
// synchronous active-low reset empties the table at once, no clearing pass.
// depends on pttf_pkg and pttf_cell
`default_nettype none

module pid_tagged_tlb_fifo #(
    parameter int ENTRIES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_op,
    input  wire logic [15:0] s_page,
    input  wire logic [7:0]  s_pid,
    input  wire logic [11:0] s_frame,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_hit,
    output logic [11:0]      m_frame_out,
    output logic [3:0]       m_slot,
    output logic             m_evicted
);

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int TOK_W  = 3 * SLOT_W + 15;
    localparam int COM_W  = 2 * SLOT_W + 3;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    typedef struct packed {
        logic                         active;
        logic                         hit;
        logic [SLOT_W-1:0]            hit_slot;
        logic [pttf_pkg::FRAME_W-1:0] hit_frame;
        logic                         free;
        logic [SLOT_W-1:0]            free_slot;
        logic [SLOT_W-1:0]            old_slot;
    } tok_t;

    typedef struct packed {
        logic              ins;
        logic              evict;
        logic              flush_all;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] new_rank;
    } commit_t;

    logic [1:0]     state_reg;
    logic [1:0]     state_next;
    pttf_pkg::cmd_t cmd_reg;
    tok_t           fin_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                m_valid_reg;
    logic                m_hit_reg;
    logic [11:0]         m_frame_reg;
    logic [3:0]          m_slot_reg;
    logic                m_evicted_reg;

    logic [TOK_W-1:0]    tok_w [ENTRIES+1];
    logic [ENTRIES-1:0]  rm_req_w;
    logic [SLOT_W-1:0]   rm_rank_w [ENTRIES];
    logic                rm_any;
    logic [SLOT_W-1:0]   rm_rank;
    tok_t                tail_tok;
    tok_t                start_tok;
    commit_t             commit;

    logic s_xfer;
    logic fire;
    logic is_lookup;
    logic is_inval;
    logic is_insert;
    logic [SLOT_W-1:0] ins_slot;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign fire    = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign is_lookup = (cmd_reg.op == pttf_pkg::OP_LOOKUP);
    assign is_inval  = (cmd_reg.op == pttf_pkg::OP_INVAL);
    assign is_insert = (cmd_reg.op == pttf_pkg::OP_INSERT);

    always_comb begin
        start_tok        = '0;
        start_tok.active = s_xfer;
    end

    assign tok_w[0] = start_tok;
    assign tail_tok = tok_t'(tok_w[ENTRIES]);

    // removal rank bus: only the cell holding the token can drive a nonzero rank
    always_comb begin
        rm_any  = |rm_req_w;
        rm_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            rm_rank = rm_rank | rm_rank_w[i];
        end
    end

    assign ins_slot = fin_reg.free ? fin_reg.free_slot : fin_reg.old_slot;

    always_comb begin
        commit           = '0;
        commit.ins       = fire && is_insert;
        commit.evict     = !fin_reg.free;
        commit.flush_all = fire && (cmd_reg.op == pttf_pkg::OP_FLUSH_ALL);
        commit.slot      = ins_slot;
        // a free slot exists only while count is below ENTRIES
        commit.new_rank  = fin_reg.free ? count_reg[SLOT_W-1:0] : SLOT_W'(ENTRIES - 1);
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            pttf_cell #(
                .SLOT_W (SLOT_W),
                .IDX    (g)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd_reg),
                .tok_in      (tok_w[g]),
                .tok_out     (tok_w[g+1]),
                .rm_any      (rm_any),
                .rm_rank     (rm_rank),
                .rm_req      (rm_req_w[g]),
                .rm_rank_out (rm_rank_w[g]),
                .commit_in   (COM_W'(commit))
            );
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) state_next = ST_WALK;
            end
            ST_WALK: begin
                if (tail_tok.active) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (fire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (commit.flush_all) begin
            count_next = '0;
        end else if (commit.ins && fin_reg.free) begin
            count_next = count_reg + CNT_W'(1);
        end else if ((state_reg == ST_WALK) && rm_any) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cmd_reg.op    <= s_op;
            cmd_reg.page  <= s_page;
            cmd_reg.pid   <= s_pid;
            cmd_reg.frame <= s_frame;
        end
        if ((state_reg == ST_WALK) && tail_tok.active) begin
            fin_reg <= tail_tok;
        end
        if (fire) begin
            m_hit_reg     <= (is_lookup || is_inval) && fin_reg.hit;
            m_frame_reg   <= (is_lookup && fin_reg.hit) ? fin_reg.hit_frame : '0;
            m_evicted_reg <= is_insert && !fin_reg.free;
            if (is_insert) begin
                m_slot_reg <= pttf_pkg::SLOT_OUT_W'(ins_slot);
            end else if ((is_lookup || is_inval) && fin_reg.hit) begin
                m_slot_reg <= pttf_pkg::SLOT_OUT_W'(fin_reg.hit_slot);
            end else begin
                m_slot_reg <= '0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = m_hit_reg;
    assign m_frame_out = m_frame_reg;
    assign m_slot      = m_slot_reg;
    assign m_evicted   = m_evicted_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pttf_cell.sv -----
// one tlb slot: entry contents, its fifo rank and one stage of the token chain
// depends on pttf_pkg
`default_nettype none

module pttf_cell #(
    parameter int SLOT_W = 4,
    parameter int IDX    = 0
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire pttf_pkg::cmd_t          cmd,
    input  wire logic [3*SLOT_W+15-1:0]  tok_in,
    output logic      [3*SLOT_W+15-1:0]  tok_out,
    input  wire logic                    rm_any,
    input  wire logic [SLOT_W-1:0]       rm_rank,
    output logic                         rm_req,
    output logic      [SLOT_W-1:0]       rm_rank_out,
    input  wire logic [2*SLOT_W+3-1:0]   commit_in
);

    typedef struct packed {
        logic                         active;
        logic                         hit;
        logic [SLOT_W-1:0]            hit_slot;
        logic [pttf_pkg::FRAME_W-1:0] hit_frame;
        logic                         free;
        logic [SLOT_W-1:0]            free_slot;
        logic [SLOT_W-1:0]            old_slot;
    } tok_t;

    typedef struct packed {
        logic              ins;
        logic              evict;
        logic              flush_all;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] new_rank;
    } commit_t;

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

    tok_t    tok_reg;
    tok_t    tok_next;
    commit_t commit;

    logic                          valid_reg;
    logic [pttf_pkg::PAGE_W-1:0]   page_reg;
    logic [pttf_pkg::PID_W-1:0]    pid_reg;
    logic [pttf_pkg::FRAME_W-1:0]  frame_reg;
    logic [SLOT_W-1:0]             rank_reg;

    logic pid_match;
    logic full_match;
    logic take_hit;
    logic load_here;

    assign commit     = commit_t'(commit_in);
    assign pid_match  = valid_reg && (pid_reg == cmd.pid);
    assign full_match = pid_match && (page_reg == cmd.page);
    assign take_hit   = tok_reg.active && !tok_reg.hit && full_match &&
                        ((cmd.op == pttf_pkg::OP_LOOKUP) || (cmd.op == pttf_pkg::OP_INVAL));
    assign load_here  = commit.ins && (commit.slot == MY_SLOT);

    // only one cell holds the active token, so at most one removal per cycle
    assign rm_req = tok_reg.active &&
                    (((cmd.op == pttf_pkg::OP_INVAL) && take_hit) ||
                     ((cmd.op == pttf_pkg::OP_FLUSH_PID) && pid_match));
    assign rm_rank_out = rm_req ? rank_reg : '0;

    always_comb begin
        tok_next = tok_reg;
        if (take_hit) begin
            tok_next.hit       = 1'b1;
            tok_next.hit_slot  = MY_SLOT;
            tok_next.hit_frame = frame_reg;
        end
        if (tok_reg.active && (cmd.op == pttf_pkg::OP_INSERT)) begin
            if (!valid_reg && !tok_reg.free) begin
                tok_next.free      = 1'b1;
                tok_next.free_slot = MY_SLOT;
            end
            if (valid_reg && (rank_reg == '0)) begin
                tok_next.old_slot = MY_SLOT;
            end
        end
    end

    assign tok_out = tok_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            tok_reg <= tok_t'(tok_in);
            if (commit.flush_all || rm_req) begin
                valid_reg <= 1'b0;
            end else if (load_here) begin
                valid_reg <= 1'b1;
            end
        end
    end

    // contents and rank only mean something while the slot is valid
    always_ff @(posedge aclk) begin
        if (load_here) begin
            page_reg  <= cmd.page;
            pid_reg   <= cmd.pid;
            frame_reg <= cmd.frame;
            rank_reg  <= commit.new_rank;
        end else if (commit.ins && commit.evict) begin
            rank_reg <= rank_reg - SLOT_W'(1);
        end else if (rm_any && (rank_reg > rm_rank)) begin
            rank_reg <= rank_reg - SLOT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pttf_checker.sv -----
// port-level checks for pid_tagged_tlb_fifo, attached by bind
// depends on pid_tagged_tlb_fifo ports only
`default_nettype none

module pttf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_hit,
    input wire logic [11:0] m_frame_out,
    input wire logic [3:0]  m_slot,
    input wire logic        m_evicted
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_frame_out) &&
        $stable(m_slot) && $stable(m_evicted))
        else $error("result changed while stalled");

    // one item at a time: input closes after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_miss_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_frame_out == 12'd0)
        else $error("frame on a miss");

    a_evict_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted |-> !m_hit)
        else $error("eviction flagged with hit");

endmodule

bind pid_tagged_tlb_fifo pttf_checker u_pttf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_hit       (m_hit),
    .m_frame_out (m_frame_out),
    .m_slot      (m_slot),
    .m_evicted   (m_evicted)
);

`default_nettype wire

// ----- test/pid_tagged_tlb_fifo_test.sv -----
// self-checking bench for pid_tagged_tlb_fifo: directed table, then random traffic
// with bursts, back-pressure and a local model of the table; uses pttf_pkg and the rtl
`default_nettype none

module pid_tagged_tlb_fifo_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pttf_pkg::*;

    localparam int TLB_ENTRIES  = 16;
    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1200;
    localparam int PAUSE_AT     = 700;
    localparam int NO_GAP_FIRST = 400;
    localparam int NO_GAP_LAST  = 560;
    localparam int HOLD_AFTER   = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * (TLB_ENTRIES + 2) + 8;
    localparam int IDLE_LIMIT   = 4000;

    // op codes the block must ignore
    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_W-1:0]    frame_out;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evicted;
    } tlb_result_t;

    localparam tlb_result_t NO_HIT = '0;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [PAGE_W-1:0]  page;
        logic [PID_W-1:0]   pid;
        logic [FRAME_W-1:0] frame;
        logic [4:0]         reps;
        logic               fixed;
        tlb_result_t        want;
    } plan_row_t;

    localparam int PLAN_ROWS = 21;

    // rows with reps > 1 step page and frame by one per repeat
    plan_row_t plan [PLAN_ROWS] = '{
        '{OP_LOOKUP,    16'h0000, 8'h00, 12'h000, 5'd1,  1'b1, NO_HIT},
        '{OP_INVAL,     16'hffff, 8'hff, 12'hfff, 5'd1,  1'b1, NO_HIT},
        '{OP_INSERT,    16'h0000, 8'h00, 12'h000, 5'd1,  1'b1, '{1'b0, 12'h000, 4'd0, 1'b0}},
        '{OP_INSERT,    16'hffff, 8'hff, 12'hfff, 5'd1,  1'b1, '{1'b0, 12'h000, 4'd1, 1'b0}},
        '{OP_INSERT,    16'hffff, 8'hff, 12'h5a5, 5'd1,  1'b1, '{1'b0, 12'h000, 4'd2, 1'b0}},
        '{OP_INSERT,    16'h0100, 8'h12, 12'h0a0, 5'd13, 1'b0, NO_HIT},
        '{OP_INSERT,    16'hbeef, 8'h80, 12'h800, 5'd1,  1'b1, '{1'b0, 12'h000, 4'd0, 1'b1}},
        '{OP_LOOKUP,    16'hffff, 8'hff, 12'h000, 5'd1,  1'b1, '{1'b1, 12'hfff, 4'd1, 1'b0}},
        '{OP_INVAL,     16'hffff, 8'hff, 12'h000, 5'd1,  1'b1, '{1'b1, 12'h000, 4'd1, 1'b0}},
        '{OP_LOOKUP,    16'hffff, 8'hff, 12'h000, 5'd1,  1'b1, '{1'b1, 12'h5a5, 4'd2, 1'b0}},
        '{OP_INSERT,    16'h1234, 8'h34, 12'h777, 5'd1,  1'b1, '{1'b0, 12'h000, 4'd1, 1'b0}},
        '{OP_INSERT,    16'h4321, 8'h43, 12'h111, 5'd1,  1'b1, '{1'b0, 12'h000, 4'd2, 1'b1}},
        '{OP_LOOKUP,    16'h0105, 8'h12, 12'h000, 5'd1,  1'b0, NO_HIT},
        '{OP_RSVD_FIRST, 16'hffff, 8'hff, 12'hfff, 5'd1, 1'b1, NO_HIT},
        '{OP_RSVD_LAST, 16'h0105, 8'h12, 12'h000, 5'd1,  1'b1, NO_HIT},
        '{OP_FLUSH_PID, 16'h0000, 8'h12, 12'h000, 5'd1,  1'b1, NO_HIT},
        '{OP_LOOKUP,    16'h0105, 8'h12, 12'h000, 5'd1,  1'b1, NO_HIT},
        '{OP_LOOKUP,    16'hbeef, 8'h80, 12'h000, 5'd1,  1'b1, '{1'b1, 12'h800, 4'd0, 1'b0}},
        '{OP_INSERT,    16'h5555, 8'haa, 12'haaa, 5'd1,  1'b0, NO_HIT},
        '{OP_FLUSH_ALL, 16'hffff, 8'hff, 12'hfff, 5'd1,  1'b1, NO_HIT},
        '{OP_LOOKUP,    16'hbeef, 8'h80, 12'h000, 5'd1,  1'b1, NO_HIT}
    };

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [OP_W-1:0]    s_op;
    logic [PAGE_W-1:0]  s_page;
    logic [PID_W-1:0]   s_pid;
    logic [FRAME_W-1:0] s_frame;
    logic               m_valid;
    logic               m_ready;
    logic               m_hit;
    logic [FRAME_W-1:0] m_frame_out;
    logic [3:0]         m_slot;
    logic               m_evicted;

    // local copy of the table contents and insertion order
    logic               tlb_valid [TLB_ENTRIES];
    logic [PAGE_W-1:0]  tlb_page  [TLB_ENTRIES];
    logic [PID_W-1:0]   tlb_pid   [TLB_ENTRIES];
    logic [FRAME_W-1:0] tlb_frame [TLB_ENTRIES];
    logic [3:0]         age_q [$];

    tlb_result_t pending_results [$];
    int          items_taken = 0;
    int          fail_count = 0;
    int          idle_cycles = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    pid_tagged_tlb_fifo #(
        .ENTRIES(TLB_ENTRIES)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_page     (s_page),
        .s_pid      (s_pid),
        .s_frame    (s_frame),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hit      (m_hit),
        .m_frame_out(m_frame_out),
        .m_slot     (m_slot),
        .m_evicted  (m_evicted)
    );

    function automatic int tlb_find(logic [PAGE_W-1:0] page, logic [PID_W-1:0] pid);
        int i;
        for (i = 0; i < TLB_ENTRIES; i++) begin
            if (tlb_valid[i] && tlb_page[i] == page && tlb_pid[i] == pid)
                return i;
        end
        return -1;
    endfunction

    function automatic void tlb_drop(int s);
        int i;
        tlb_valid[s] = 1'b0;
        tlb_page[s]  = '0;
        tlb_pid[s]   = '0;
        tlb_frame[s] = '0;
        for (i = 0; i < age_q.size(); i++) begin
            if (age_q[i] == 4'(s)) begin
                age_q.delete(i);
                break;
            end
        end
    endfunction

    function automatic tlb_result_t tlb_translate(logic [OP_W-1:0] op,
                                                  logic [PAGE_W-1:0] page,
                                                  logic [PID_W-1:0] pid,
                                                  logic [FRAME_W-1:0] frame);
        tlb_result_t res;
        int          m;
        int          s;
        int          i;
        bit          found;
        res   = '0;
        s     = 0;
        found = 1'b0;
        case (op)
            OP_LOOKUP: begin
                m = tlb_find(page, pid);
                if (m >= 0) begin
                    res.hit       = 1'b1;
                    res.frame_out = tlb_frame[m];
                    res.slot      = 4'(m);
                end
            end
            OP_INSERT: begin
                for (i = 0; i < TLB_ENTRIES && !found; i++) begin
                    if (!tlb_valid[i]) begin
                        s     = i;
                        found = 1'b1;
                    end
                end
                // full table: the oldest insertion gives up its slot
                if (!found) begin
                    s           = age_q[0];
                    res.evicted = 1'b1;
                    tlb_drop(s);
                end
                tlb_valid[s] = 1'b1;
                tlb_page[s]  = page;
                tlb_pid[s]   = pid;
                tlb_frame[s] = frame;
                age_q.push_back(4'(s));
                res.slot = 4'(s);
            end
            OP_INVAL: begin
                m = tlb_find(page, pid);
                if (m >= 0) begin
                    res.hit  = 1'b1;
                    res.slot = 4'(m);
                    tlb_drop(m);
                end
            end
            OP_FLUSH_PID: begin
                for (i = 0; i < TLB_ENTRIES; i++) begin
                    if (tlb_valid[i] && tlb_pid[i] == pid)
                        tlb_drop(i);
                end
            end
            OP_FLUSH_ALL: begin
                for (i = 0; i < TLB_ENTRIES; i++) begin
                    tlb_valid[i] = 1'b0;
                    tlb_page[i]  = '0;
                    tlb_pid[i]   = '0;
                    tlb_frame[i] = '0;
                end
                age_q.delete();
            end
            default: ;
        endcase
        return res;
    endfunction

    // offer one command and hold it until the transfer; valid is left high
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] page,
                            input logic [PID_W-1:0] pid, input logic [FRAME_W-1:0] frame,
                            input logic fixed, input tlb_result_t want);
        tlb_result_t predicted;
        s_valid <= 1'b1;
        s_op    <= op;
        s_page  <= page;
        s_pid   <= pid;
        s_frame <= frame;
        do @(posedge aclk); while (!s_ready);
        predicted = tlb_translate(op, page, pid, frame);
        pending_results.push_back(fixed ? want : predicted);
        items_taken++;
    endtask

    initial begin : stimulus
        logic [PID_W-1:0]   pid_pool [4];
        logic [OP_W-1:0]    op;
        logic [PAGE_W-1:0]  page;
        logic [PID_W-1:0]   pid;
        logic [FRAME_W-1:0] frame;
        int                 r;
        int                 k;
        int                 n;
        int                 sel;
        int                 gap;
        int                 burst_left;
        pid_pool = '{8'h00, 8'hff, 8'h5a, 8'ha5};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op    = '0;
        s_page  = '0;
        s_pid   = '0;
        s_frame = '0;
        void'(tlb_translate(OP_FLUSH_ALL, '0, '0, '0));
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < PLAN_ROWS; r++) begin
            for (k = 0; k < plan[r].reps; k++)
                send_cmd(plan[r].op, plan[r].page + PAGE_W'(k), plan[r].pid,
                         plan[r].frame + FRAME_W'(k), plan[r].fixed, plan[r].want);
        end

        burst_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PAUSE_AT) begin
                // let the block drain completely before going on
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_results.size() != 0);
                burst_left = $urandom_range(1, 12);
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = 0;
                if ((n < NO_GAP_FIRST || n >= NO_GAP_LAST) && $urandom_range(0, 2) != 0)
                    gap = $urandom_range(1, 40);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end

            sel   = $urandom_range(0, 99);
            page  = ($urandom_range(0, 9) < 6) ? PAGE_W'($urandom_range(0, 15))
                                                : PAGE_W'($urandom);
            pid   = ($urandom_range(0, 3) != 0) ? pid_pool[$urandom_range(0, 3)]
                                                 : PID_W'($urandom);
            frame = FRAME_W'($urandom);
            if (sel < 38)
                op = OP_INSERT;
            else if (sel < 72)
                op = OP_LOOKUP;
            else if (sel < 86)
                op = OP_INVAL;
            else if (sel < 92)
                op = OP_FLUSH_PID;
            else if (sel < 94)
                op = OP_FLUSH_ALL;
            else
                op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            // mostly aim searches at something that is actually in the table
            if ((op == OP_LOOKUP || op == OP_INVAL || op == OP_FLUSH_PID)
                    && $urandom_range(0, 9) < 7) begin
                k = $urandom_range(0, TLB_ENTRIES - 1);
                if (tlb_valid[k]) begin
                    page = tlb_page[k];
                    pid  = tlb_pid[k];
                end
            end
            send_cmd(op, page, pid, frame, 1'b0, NO_HIT);
            burst_left--;
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS pid_tagged_tlb_fifo");
        else
            $display("FAIL pid_tagged_tlb_fifo");
        $finish;
    end

    // result side: stall pattern is picked anew for every run, plus one long hold-off
    initial begin : result_sink
        int  mode;
        int  run;
        bit  held_off;
        held_off = 1'b0;
        m_ready  = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(16, 96);
            repeat (run) begin
                @(posedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 7) != 0);
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
            if (!held_off && items_taken >= HOLD_AFTER) begin
                held_off = 1'b1;
                @(posedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        tlb_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: hit %0d frame_out %0h slot %0d",
                       m_hit, m_frame_out, m_slot);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, m_hit);
                    fail_count++;
                end
                if (m_frame_out !== want.frame_out) begin
                    $error("frame_out: expected %0h, got %0h", want.frame_out, m_frame_out);
                    fail_count++;
                end
                if (m_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, m_slot);
                    fail_count++;
                end
                if (m_evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, m_evicted);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("no transfer for %0d cycles, %0d results outstanding",
                       idle_cycles, pending_results.size());
                $display("FAIL pid_tagged_tlb_fifo");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
